// ===== rtl/grd_pkg.sv =====
// ============================================================================
// grd_pkg: shared types and constants for the grid ray caster
// Item command codes, config indices, distance limit, queue entry layout and
// walker state encoding.
package grd_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    localparam int CFG_COLS = 0;
    localparam int CFG_ROWS = 1;

    localparam logic [16:0] DIST_MAX = 17'h1FFFF;

    // One queued item between the front and the back part
    typedef struct packed {
        logic        cmd;
        logic [5:0]  cell_col;
        logic [5:0]  cell_row;
        logic        cell_is_wall;
        logic [15:0] view_x;
        logic [15:0] view_y;
        logic [1:0]  quadrant;
        logic [15:0] slope;
    } item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_VSETUP,
        ST_HSETUP,
        ST_PROBE,
        ST_READ,
        ST_CHECK,
        ST_SQ,
        ST_SQRT,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/grid_raycast_wall_distance_top.sv =====
// ============================================================================
// grid_raycast_wall_distance_top: grid ray caster, wall distance
// Holds a one-bit wall map and casts rays against it.
// ============================================================================
// Usage:
//   An item is taken when start is high and busy is low. cmd 0 writes one map
//   cell and gives no result; cmd 1 casts a ray and gives one result: distance
//   and hit, shown with done high for a single cycle.
//   Items pass a two-entry queue into the walker, so busy rises only when
//   both slots are taken.
//   A map write and a cast each hold the walker. A cast runs two 27-step
//   restoring divisions giving offset and step of the horizontal walk, then
//   setup, one map RAM read per grid crossing probed and a bit-pair square
//   root per wall hit before the result.
//   Reset clears control, sets map_columns and map_rows to 64 and starts a
//   pass that clears all 4096 map RAM cells one cell per cycle; items queue
//   up meanwhile. The receiver cannot stall: results are dropped if not
//   taken in their cycle. Configuration (cfg_we, cfg_index, cfg_data) is
//   to be written only while idle; the block itself does not enforce this.
// ============================================================================
module grid_raycast_wall_distance_top
    import grd_pkg::*;
#(
    parameter int MAP_SIDE  = 64,
    parameter int FRAC_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [5:0]  cell_col,
    input  logic [5:0]  cell_row,
    input  logic        cell_is_wall,
    input  logic [15:0] view_x,
    input  logic [15:0] view_y,
    input  logic [1:0]  quadrant,
    input  logic [15:0] slope,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    output logic        done,
    output logic [16:0] distance,
    output logic        hit
);

    logic [6:0] cols_reg, rows_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= 7'd64;
            rows_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'(CFG_COLS)) cols_reg <= cfg_data;
            else                           rows_reg <= cfg_data;
        end
    end

    item_t in_item, head;
    logic  full, avail, pop, push;
    assign in_item = '{cmd, cell_col, cell_row, cell_is_wall, view_x, view_y, quadrant, slope};
    assign busy = full;
    assign push = start && !full;

    grd_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .push_item(in_item),
        .full(full), .avail(avail), .pop(pop), .head(head)
    );

    grd_back #(.MAP_SIDE(MAP_SIDE), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .avail(avail), .head(head), .pop(pop),
        .map_columns(cols_reg), .map_rows(rows_reg),
        .done(done), .distance(distance), .hit(hit)
    );

`ifndef SYNTH
    a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !push) else $error("push while busy");
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> $stable(cols_reg) && $stable(rows_reg)) else $error("cfg changed");
    a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> distance == 17'd0) else $error("distance without hit");
`endif

endmodule

// ===== rtl/grd_ram.sv =====
// ============================================================================
// grd_ram: generic single-port RAM with registered read
// One address each cycle: always a read, plus a write when we is high (read gives old data).
// ============================================================================
module grd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/grd_front.sv =====
// ============================================================================
// grd_front: item intake and two-entry queue
// Captures each started item and hands it to the back part in order.
// ============================================================================
module grd_front
    import grd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    output logic  avail,
    input  logic  pop,
    output item_t head
);

    item_t      slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;

    assign full  = (cnt_reg == 2'd2);
    assign avail = (cnt_reg != 2'd0);
    assign head  = slot_reg[rd_reg];

    // occupancy count
    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push) wr_reg <= ~wr_reg;
            if (pop)  rd_reg <= ~rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_item;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !avail |-> !pop) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("bad count");
`endif

endmodule

// ===== rtl/grd_back.sv =====
// ============================================================================
// grd_back: map store and ray walker
// Clears the map after reset, writes map cells, walks vertical then horizontal
// crossings, computes the horizontal offset and step (a reciprocal) by restoring
// division and the distance by a bit-pair sqrt.
// ============================================================================
module grd_back
    import grd_pkg::*;
#(
    parameter int MAP_SIDE  = 64,
    parameter int FRAC_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        avail,
    input  item_t       head,
    output logic        pop,
    input  logic [6:0]  map_columns,
    input  logic [6:0]  map_rows,
    output logic        done,
    output logic [16:0] distance,
    output logic        hit
);

    localparam int IFB  = FRAC_BITS + 8;
    localparam int SB   = $clog2(MAP_SIDE);
    localparam int AW   = 2 * SB;
    localparam int PW   = IFB + SB + 10;          // signed position width
    localparam int CW   = PW - IFB + 1;           // signed cell index
    localparam int DW   = FRAC_BITS + 17;         // dividend width
    localparam int QW   = FRAC_BITS + 17;         // quotient width
    localparam int GW   = $clog2(2 * MAP_SIDE + 5);
    localparam int VW   = 2 * (PW - 8);           // squared sum width
    localparam int RW   = VW / 2 + 1;
    localparam int SCW  = $clog2(VW / 2 + 1);
    localparam int DCW  = $clog2(DW + 1);

    typedef logic signed [PW-1:0] pos_t;

    state_t st_reg, st_next;

    // item and walk registers
    item_t              it_reg;
    logic signed [CW-1:0] line_reg;
    pos_t               along_reg, astep_reg;
    logic               horiz_reg;
    logic [GW-1:0]      guard_reg;
    logic               hitv_reg, hith_reg;
    logic [RW-1:0]      best_reg;
    pos_t               hx_reg, hy_reg;
    logic [VW-1:0]      rem_reg;
    logic [RW-1:0]      root_reg;
    logic [SCW-1:0]     scnt_reg;
    logic [DW-1:0]      dnum_reg;
    logic [16:0]        dacc_reg;
    logic [QW-1:0]      quot_reg;
    logic [DCW-1:0]     dcnt_reg;
    logic               dphase_reg;     // 0: offset, 1: step
    logic [QW-1:0]      xoff_reg;
    logic [AW-1:0]      clr_reg;        // map clear address after reset

    // derived item values
    logic right, down;
    logic [15:0] px, py;
    logic [5:0] fx, fy;
    logic [FRAC_BITS:0] dxq, dyq;
    pos_t vx, vy;
    assign right = ~it_reg.quadrant[1];
    assign down  = ~it_reg.quadrant[0];
    assign px = it_reg.view_x;
    assign py = it_reg.view_y;
    assign fx = px[15:FRAC_BITS];
    assign fy = py[15:FRAC_BITS];
    assign dxq = right ? ((FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, px[FRAC_BITS-1:0]})
                       : {1'b0, px[FRAC_BITS-1:0]};
    assign dyq = down ? ((FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, py[FRAC_BITS-1:0]})
                      : {1'b0, py[FRAC_BITS-1:0]};
    assign vx = PW'({px, 8'd0});
    assign vy = PW'({py, 8'd0});

    // effective map size
    logic [7:0] cols, rows;
    assign cols = ({1'b0, map_columns} > 8'(MAP_SIDE)) ? 8'(MAP_SIDE) : {1'b0, map_columns};
    assign rows = ({1'b0, map_rows} > 8'(MAP_SIDE)) ? 8'(MAP_SIDE) : {1'b0, map_rows};

    // current probe cell
    logic signed [CW-1:0] pc, pr, lc, ac;
    logic inmap;
    assign lc = line_reg + ((horiz_reg ? down : right) ? CW'(0) : -CW'(1));
    assign ac = along_reg[PW-1] ? -CW'(1) : CW'(along_reg >>> IFB);
    assign pc = horiz_reg ? ac : lc;
    assign pr = horiz_reg ? lc : ac;
    assign inmap = !pc[CW-1] && !pr[CW-1]
                && (pc[CW-2:0] < (CW-1)'(cols)) && (pr[CW-2:0] < (CW-1)'(rows));

    // memory
    logic          ram_we, ram_q, ram_wd;
    logic [AW-1:0] ram_addr;
    grd_ram #(.WIDTH(1), .DEPTH(MAP_SIDE * MAP_SIDE)) u_map (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_q)
    );

    // hit point and distance terms
    pos_t lpos, hxw, hyw, ddx, ddy;
    logic [PW-9:0] ax, ay;
    assign lpos = pos_t'(line_reg) <<< IFB;
    assign hxw = horiz_reg ? along_reg : lpos;
    assign hyw = horiz_reg ? lpos : along_reg;
    assign ddx = hx_reg - vx;
    assign ddy = hy_reg - vy;
    assign ax = (PW-8)'((ddx[PW-1] ? -ddx : ddx) >> 8);
    assign ay = (PW-8)'((ddy[PW-1] ? -ddy : ddy) >> 8);

    // sqrt step, two bits per cycle
    logic [VW-1:0]  trial;
    logic [RW+1:0]  tr;
    assign trial = rem_reg;
    assign tr = {root_reg, 2'b01};

    // division step
    logic [17:0] dsub;
    assign dsub = {dacc_reg, dnum_reg[DW-1]} - {2'b0, it_reg.slope};

    logic [RW-1:0] newd;

    always_comb
    begin
        st_next  = st_reg;
        pop      = 1'b0;
        ram_we   = 1'b0;
        ram_wd   = it_reg.cell_is_wall;
        ram_addr = AW'({pr[SB-1:0], pc[SB-1:0]});
        done     = 1'b0;
        newd     = root_reg;
        case (st_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_wd   = 1'b0;
                ram_addr = clr_reg;
                if (clr_reg == '1) st_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (avail) pop = 1'b1;
                if (avail) st_next = (head.cmd == CMD_WRITE) ? ST_DONE : ST_DIV;
            end
            ST_DIV:   if (dcnt_reg == '0 && dphase_reg) st_next = ST_VSETUP;
            ST_VSETUP: st_next = ST_PROBE;
            ST_HSETUP: st_next = (it_reg.slope == 16'd0) ? ST_DONE : ST_PROBE;
            ST_PROBE:
            begin
                if (!inmap || guard_reg == GW'(2 * MAP_SIDE + 4))
                    st_next = horiz_reg ? ST_DONE : ST_HSETUP;
                else
                    st_next = ST_READ;
            end
            ST_READ:  st_next = ST_CHECK;
            ST_CHECK: st_next = ram_q ? ST_SQ : ST_PROBE;
            ST_SQ:    st_next = ST_SQRT;
            ST_SQRT:
            begin
                if (scnt_reg == '0)
                    st_next = horiz_reg ? ST_DONE : ST_HSETUP;
            end
            ST_DONE:
            begin
                if (it_reg.cmd == CMD_WRITE)
                begin
                    ram_addr = AW'({it_reg.cell_row[SB-1:0], it_reg.cell_col[SB-1:0]});
                    ram_we = (32'(it_reg.cell_col) < MAP_SIDE)
                          && (32'(it_reg.cell_row) < MAP_SIDE);
                end
                else
                begin
                    done = 1'b1;
                end
                st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ST_CLEAR;
        else
            st_reg <= st_next;
    end

    // clear address, one map cell per cycle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (st_reg == ST_CLEAR)
            clr_reg <= clr_reg + 1'b1;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (st_reg)
            ST_IDLE:
            begin
                it_reg     <= head;
                hitv_reg   <= 1'b0;
                hith_reg   <= 1'b0;
                best_reg   <= '0;
                horiz_reg  <= 1'b0;
                dphase_reg <= 1'b0;
                dcnt_reg   <= DCW'(DW);
                dacc_reg   <= '0;
                quot_reg   <= '0;
                dnum_reg   <= '0;
            end
            ST_DIV:
            begin
                if (dcnt_reg == DCW'(DW))
                begin
                    dnum_reg <= dphase_reg ? DW'(1) << (FRAC_BITS + 16)
                                           : DW'({dyq, 16'd0});
                    dacc_reg <= '0;
                    quot_reg <= '0;
                    dcnt_reg <= dcnt_reg - 1'b1;
                end
                else
                begin
                    if (!dsub[17])
                    begin
                        dacc_reg <= dsub[16:0];
                        quot_reg <= {quot_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        dacc_reg <= {dacc_reg[15:0], dnum_reg[DW-1]};
                        quot_reg <= {quot_reg[QW-2:0], 1'b0};
                    end
                    dnum_reg <= {dnum_reg[DW-2:0], 1'b0};
                    if (dcnt_reg == '0)
                    begin
                        dphase_reg <= 1'b1;
                        dcnt_reg   <= DCW'(DW);
                        if (!dphase_reg)
                            xoff_reg <= !dsub[17] ? {quot_reg[QW-2:0], 1'b1}
                                                  : {quot_reg[QW-2:0], 1'b0};
                    end
                    else
                        dcnt_reg <= dcnt_reg - 1'b1;
                end
            end
            ST_VSETUP:
            begin
                horiz_reg <= 1'b0;
                guard_reg <= '0;
                line_reg  <= right ? CW'(fx) + CW'(1) : CW'(fx);
                along_reg <= down ? vy + pos_t'(dxq * it_reg.slope)
                                  : vy - pos_t'(dxq * it_reg.slope);
                astep_reg <= down ? pos_t'({it_reg.slope, {FRAC_BITS{1'b0}}})
                                  : -pos_t'({it_reg.slope, {FRAC_BITS{1'b0}}});
            end
            ST_HSETUP:
            begin
                horiz_reg <= 1'b1;
                guard_reg <= '0;
                line_reg  <= down ? CW'(fy) + CW'(1) : CW'(fy);
                along_reg <= right ? vx + pos_t'(xoff_reg) : vx - pos_t'(xoff_reg);
                astep_reg <= right ? pos_t'(quot_reg) : -pos_t'(quot_reg);
            end
            ST_CHECK:
            begin
                if (ram_q)
                begin
                    hx_reg <= hxw;
                    hy_reg <= hyw;
                end
                else
                begin
                    line_reg  <= line_reg + (((horiz_reg ? down : right)) ? CW'(1) : -CW'(1));
                    along_reg <= along_reg + astep_reg;
                    guard_reg <= guard_reg + 1'b1;
                end
            end
            ST_SQ:
            begin
                rem_reg  <= VW'(ax * ax) + VW'(ay * ay);
                root_reg <= '0;
                scnt_reg <= SCW'(VW / 2);
            end
            ST_SQRT:
            begin
                if (scnt_reg != '0)
                begin
                    if ((trial >> (2 * (scnt_reg - 1'b1))) >= VW'(tr))
                    begin
                        rem_reg  <= rem_reg - (VW'(tr) << (2 * (scnt_reg - 1'b1)));
                        root_reg <= {root_reg[RW-2:0], 1'b1};
                    end
                    else
                        root_reg <= {root_reg[RW-2:0], 1'b0};
                    scnt_reg <= scnt_reg - 1'b1;
                end
                else
                begin
                    if (!horiz_reg) hitv_reg <= 1'b1;
                    else            hith_reg <= 1'b1;
                    if (!hitv_reg || newd < best_reg) best_reg <= newd;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign hit = hitv_reg | hith_reg;
    assign distance = !hit ? 17'd0 : (best_reg > RW'(DIST_MAX)) ? DIST_MAX : 17'(best_reg);

`ifndef SYNTH
    a_done_cast: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> it_reg.cmd == CMD_CAST) else $error("result for write");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> st_reg == ST_IDLE) else $error("pop outside idle");
    a_we_done: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (st_reg == ST_DONE || st_reg == ST_CLEAR)) else $error("stray map write");
`endif

endmodule
